### hdl/icms_pkg.sv
package icms_pkg;

    // Default depth of the value store
    localparam int MAX_ITEMS_DEF = 1024;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 31;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } icms_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] inversion_count;
        logic               overflowed;
    } icms_out_t;

    // Sequencer step addresses
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_LOAD      = 3'd0;
    localparam logic [STEP_W-1:0] STEP_PASS_CHK  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_BLK_SETUP = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MERGE     = 3'd3;
    localparam logic [STEP_W-1:0] STEP_BLK_NEXT  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PASS_NEXT = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd6;

    // Datapath actions
    localparam int ACT_W = 3;
    localparam logic [ACT_W-1:0] ACT_LOAD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PASS_CHK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BLK_SETUP = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MERGE     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BLK_NEXT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PASS_NEXT = 3'd5;
    localparam logic [ACT_W-1:0] ACT_EMIT      = 3'd6;
    localparam logic [ACT_W-1:0] ACT_NOP       = 3'd7;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_ALWAYS     = 3'd0;
    localparam logic [COND_W-1:0] COND_LAST_ACC   = 3'd1;
    localparam logic [COND_W-1:0] COND_WIDTH_DONE = 3'd2;
    localparam logic [COND_W-1:0] COND_MERGE_DONE = 3'd3;
    localparam logic [COND_W-1:0] COND_LO_DONE    = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] jump_t;
        logic [STEP_W-1:0] jump_f;
    } icms_ucw_t;

    // Control program: one word per step
    function automatic icms_ucw_t icms_ucode(input logic [STEP_W-1:0] step);
        icms_ucw_t w;
        begin
            case (step)
                STEP_LOAD:      w = '{ACT_LOAD, COND_LAST_ACC, STEP_PASS_CHK, STEP_LOAD};
                STEP_PASS_CHK:  w = '{ACT_PASS_CHK, COND_WIDTH_DONE, STEP_EMIT,
                                      STEP_BLK_SETUP};
                STEP_BLK_SETUP: w = '{ACT_BLK_SETUP, COND_ALWAYS, STEP_MERGE, STEP_MERGE};
                STEP_MERGE:     w = '{ACT_MERGE, COND_MERGE_DONE, STEP_BLK_NEXT, STEP_MERGE};
                STEP_BLK_NEXT:  w = '{ACT_BLK_NEXT, COND_LO_DONE, STEP_PASS_NEXT,
                                      STEP_BLK_SETUP};
                STEP_PASS_NEXT: w = '{ACT_PASS_NEXT, COND_ALWAYS, STEP_PASS_CHK,
                                      STEP_PASS_CHK};
                STEP_EMIT:      w = '{ACT_EMIT, COND_ALWAYS, STEP_LOAD, STEP_LOAD};
                default:        w = '{ACT_NOP, COND_ALWAYS, STEP_LOAD, STEP_LOAD};
            endcase
            return w;
        end
    endfunction

endpackage

### hdl/inversion_count_merge_sort_top.sv
// Inversion counter over a sequence of signed 32-bit values.
//
// Input channel: a word (value, last) is taken at a clock edge where start is
// high and busy is low. Words without last are taken one per cycle and keep busy
// low. Words past MAX_ITEMS are dropped and raise the overflow flag.
// The word with last set closes the sequence; busy then rises while a
// microcoded sequencer runs bottom-up stable merge passes over two
// ping-pong memories, adding up the inversions as it merges.
// For n stored values it runs ceil(log2 n) merge passes; the merge step
// writes one value per cycle, so the memory write port sets the pace.
// No new word is taken until the result has been given.
// Result channel: done is high for exactly one cycle with inversion_count
// and overflowed on result; the receiver cannot stall, so the word must be
// taken in that cycle. busy falls in the next cycle and a new sequence may
// start. Reset (rst_n low) returns to idle with an empty sequence; memory
// contents are not cleared and need no clearing pass.
module inversion_count_merge_sort_top #(
    parameter int MAX_ITEMS = icms_pkg::MAX_ITEMS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  icms_pkg::icms_in_t  in_data,
    output logic                done,
    output icms_pkg::icms_out_t result
);
    import icms_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

    // Ping-pong value memories
    logic signed [VALUE_W-1:0] bank0_mem [0:MAX_ITEMS-1];
    logic signed [VALUE_W-1:0] bank1_mem [0:MAX_ITEMS-1];

    // Sequencer and datapath registers
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [COUNT_W-1:0] inv_reg, inv_next;
    logic [CW:0]        width_reg, width_next;
    logic               bank_reg, bank_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      mid_reg, mid_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [CW-1:0]      k_reg, k_next;

    logic signed [VALUE_W-1:0] b0a_reg, b0b_reg, b1a_reg, b1b_reg;
    logic signed [VALUE_W-1:0] rd_i, rd_j;

    icms_ucw_t          ucw;
    logic               accept;
    logic               cond_true;
    logic [SW-1:0]      lo_w, sum_mid, sum_hi;
    logic [CW-1:0]      k_inc;
    logic               i_live, j_live, take_j, greater;

    logic               wr0_en, wr1_en;
    logic [AW-1:0]      wr0_addr, wr1_addr, rd_addr_a, rd_addr_b;
    logic signed [VALUE_W-1:0] wr0_data, wr1_data, merge_data;

    assign ucw    = icms_ucode(step_reg);
    assign accept = start && !busy;
    assign busy   = (step_reg != STEP_LOAD);
    assign done   = (step_reg == STEP_EMIT);
    assign result = '{inversion_count: inv_reg, overflowed: ovf_reg};

    // Source data of the current pass
    assign rd_i = bank_reg ? b1a_reg : b0a_reg;
    assign rd_j = bank_reg ? b1b_reg : b0b_reg;

    // Block bounds and merge decision
    assign lo_w       = SW'(lo_reg);
    assign sum_mid    = lo_w + SW'(width_reg);
    assign sum_hi     = lo_w + SW'({width_reg, 1'b0});
    assign k_inc      = k_reg + 1'b1;
    assign i_live     = (i_reg < mid_reg);
    assign j_live     = (j_reg < hi_reg);
    assign greater    = (rd_i > rd_j);
    assign take_j     = !i_live || (j_live && greater);
    assign merge_data = take_j ? rd_j : rd_i;

    // Evaluate the jump condition of the current word
    always_comb
    begin
        case (ucw.cond)
            COND_ALWAYS:     cond_true = 1'b1;
            COND_LAST_ACC:   cond_true = accept && in_data.last;
            COND_WIDTH_DONE: cond_true = (width_reg >= {1'b0, count_reg});
            COND_MERGE_DONE: cond_true = (k_inc == hi_reg);
            COND_LO_DONE:    cond_true = (sum_hi >= SW'(count_reg));
            default:         cond_true = 1'b0;
        endcase
    end

    // Datapath actions
    always_comb
    begin
        step_next  = cond_true ? ucw.jump_t : ucw.jump_f;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        inv_next   = inv_reg;
        width_next = width_reg;
        bank_next  = bank_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        wr0_en     = 1'b0;
        wr0_addr   = '0;
        wr0_data   = merge_data;
        wr1_en     = 1'b0;
        wr1_addr   = k_reg[AW-1:0];
        wr1_data   = merge_data;

        case (ucw.act)
            ACT_LOAD:
            begin
                // Store the word, or drop it once the store is full
                if (accept) begin
                    if (count_reg < MAX_C) begin
                        wr0_en     = 1'b1;
                        wr0_addr   = count_reg[AW-1:0];
                        wr0_data   = in_data.value;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ACT_PASS_CHK:
            begin
                lo_next = '0;
            end
            ACT_BLK_SETUP:
            begin
                // Clip both halves to the stored length
                mid_next = (sum_mid > SW'(count_reg)) ? count_reg : sum_mid[CW-1:0];
                hi_next  = (sum_hi > SW'(count_reg)) ? count_reg : sum_hi[CW-1:0];
                i_next   = lo_reg;
                j_next   = mid_next;
                k_next   = lo_reg;
            end
            ACT_MERGE:
            begin
                // Write one value per cycle; count the left-half remainder on a swap
                wr0_en   = bank_reg;
                wr1_en   = !bank_reg;
                wr0_addr = k_reg[AW-1:0];
                k_next   = k_inc;
                if (take_j) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                end
                if (i_live && j_live && greater) begin
                    inv_next = inv_reg + COUNT_W'(mid_reg - i_reg);
                end
            end
            ACT_BLK_NEXT:
            begin
                lo_next = sum_hi[CW-1:0];
            end
            ACT_PASS_NEXT:
            begin
                width_next = {width_reg[CW-1:0], 1'b0};
                bank_next  = !bank_reg;
            end
            ACT_EMIT:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                inv_next   = '0;
                width_next = (CW+1)'(1);
                bank_next  = 1'b0;
            end
            default:
            begin
                step_next = STEP_LOAD;
            end
        endcase
    end

    // Read addresses follow the next pointers so data is ready in the next cycle
    assign rd_addr_a = (i_next < MAX_C) ? i_next[AW-1:0] : '0;
    assign rd_addr_b = (j_next < MAX_C) ? j_next[AW-1:0] : '0;

    // Memory bank 0
    always_ff @(posedge clk)
    begin
        if (wr0_en) begin
            bank0_mem[wr0_addr] <= wr0_data;
        end
        b0a_reg <= bank0_mem[rd_addr_a];
        b0b_reg <= bank0_mem[rd_addr_b];
    end

    // Memory bank 1
    always_ff @(posedge clk)
    begin
        if (wr1_en) begin
            bank1_mem[wr1_addr] <= wr1_data;
        end
        b1a_reg <= bank1_mem[rd_addr_a];
        b1b_reg <= bank1_mem[rd_addr_b];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg  <= STEP_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            inv_reg   <= '0;
            width_reg <= (CW+1)'(1);
            bank_reg  <= 1'b0;
        end else begin
            step_reg  <= step_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            inv_reg   <= inv_next;
            width_reg <= width_next;
            bank_reg  <= bank_next;
        end
    end

    // Merge pointers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
    end

endmodule

### hdl/icms_checker.sv
module icms_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input icms_pkg::icms_in_t  in_data,
    input logic                done,
    input icms_pkg::icms_out_t result
);
    import icms_pkg::*;

    // A result only appears while the sequence is being processed
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    // A word without last keeps the block ready for the next word
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !in_data.last) |=> !busy)
        else $error("busy after a non-final word");

    // The final word starts processing
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_data.last) |=> (busy && !done))
        else $error("final word did not start processing");

    // After the result the block is ready again
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("block not ready after result");

    // The result word carries known bits while it is strobed
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result))
        else $error("unknown bits in result word");

endmodule

bind inversion_count_merge_sort_top icms_checker u_icms_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .done    (done),
    .result  (result)
);

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import icms_pkg::*;

    localparam int MAX_ITEMS    = MAX_ITEMS_DEF;
    localparam int RANDOM_WORDS = 400;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [VALUE_W-1:0] value_t;

    // How the values of one sequence are filled in
    typedef enum int {
        FILL_FULL,
        FILL_NARROW,
        FILL_RISING,
        FILL_FALLING
    } fill_t;

    localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
    localparam value_t VALUE_MIN = 32'sh8000_0000;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    icms_in_t  in_data;
    logic      done;
    icms_out_t result;

    // Shadow of the sequence being collected and the results still owed
    value_t    open_values[$];
    bit        open_overflow;
    icms_out_t expected_results[$];

    int failures         = 0;
    int words_sent       = 0;
    int sequences_closed = 0;
    int results_checked  = 0;
    int overflow_closes  = 0;
    int max_gap          = 12;
    int next_gap         = 0;
    bit start_held       = 1'b0;

    inversion_count_merge_sort_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .in_data(in_data),
        .done   (done),
        .result (result)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hang guard, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("inversion_count_merge_sort_top regression: fail");
        $finish;
    end

    task automatic note_failure(input string msg);
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] %s", $realtime, msg);
        end
    endtask

    // Count pairs i<j with v[i] > v[j] by stable bottom-up merging
    function automatic longint count_inversions(input value_t vals[$]);
        value_t src[$];
        value_t dst[$];
        longint total;
        int     n;
        int     width;
        int     lo;
        int     mid;
        int     hi;
        int     i;
        int     j;
        begin
            src   = vals;
            n     = src.size();
            total = 0;
            for (width = 1; width < n; width = width * 2)
            begin
                dst = {};
                for (lo = 0; lo < n; lo = lo + 2 * width)
                begin
                    mid = (lo + width > n) ? n : lo + width;
                    hi  = (lo + 2 * width > n) ? n : lo + 2 * width;
                    i   = lo;
                    j   = mid;
                    while (i < mid && j < hi)
                    begin
                        if (src[i] > src[j])
                        begin
                            dst.push_back(src[j]);
                            j++;
                            total += mid - i;
                        end
                        else
                        begin
                            dst.push_back(src[i]);
                            i++;
                        end
                    end
                    while (i < mid)
                    begin
                        dst.push_back(src[i]);
                        i++;
                    end
                    while (j < hi)
                    begin
                        dst.push_back(src[j]);
                        j++;
                    end
                end
                src = dst;
            end
            return total;
        end
    endfunction

    // Store or drop one accepted word; close the sequence on last
    task automatic record_word(input value_t v, input bit is_last);
        longint    total;
        icms_out_t want;
        begin
            words_sent++;
            if (open_values.size() < MAX_ITEMS)
                open_values.push_back(v);
            else
                open_overflow = 1'b1;
            if (is_last)
            begin
                total                = count_inversions(open_values);
                want.inversion_count = total[COUNT_W-1:0];
                want.overflowed      = open_overflow;
                expected_results.push_back(want);
                sequences_closed++;
                if (open_overflow)
                    overflow_closes++;
                open_values   = {};
                open_overflow = 1'b0;
            end
        end
    endtask

    // Offer one word, hold it until taken, then draw the gap before the next
    task automatic send_word(input value_t v, input bit is_last);
        begin
            repeat (next_gap) @(posedge clk);
            start         <= 1'b1;
            in_data.value <= v;
            in_data.last  <= is_last;
            do
                @(posedge clk);
            while (busy);
            record_word(v, is_last);
            next_gap   = $urandom_range(max_gap, 0);
            start_held = (next_gap == 0);
            if (!start_held)
                start <= 1'b0;
        end
    endtask

    // Drop start and hold off until every owed result has come
    task automatic wait_drained();
        begin
            if (start_held)
            begin
                start      <= 1'b0;
                start_held  = 1'b0;
            end
            do
                @(posedge clk);
            while (expected_results.size() != 0);
        end
    endtask

    function automatic value_t pick_value(input fill_t fill, input int idx);
        begin
            case (fill)
                FILL_FULL:    return value_t'($urandom);
                FILL_NARROW:  return value_t'(int'($urandom_range(8, 0)) - 4);
                FILL_RISING:  return value_t'(idx * 3 - 100);
                default:      return value_t'(100 - idx * 3);
            endcase
        end
    endfunction

    task automatic send_sequence(input int len, input fill_t fill);
        int k;
        begin
            for (k = 0; k < len; k++)
                send_word(pick_value(fill, k), k == len - 1);
        end
    endtask

    // One-word sequences of zero and the value extremes
    task automatic test_single_word();
        begin
            max_gap = 12;
            send_word('0, 1'b1);
            send_word(VALUE_MIN, 1'b1);
            send_word(VALUE_MAX, 1'b1);
            wait_drained();
        end
    endtask

    // Signed extremes mixed in one sequence, with repeats
    task automatic test_extreme_values();
        value_t vals[$];
        int     k;
        begin
            vals = {VALUE_MAX, VALUE_MIN, value_t'(0), value_t'(-1),
                    VALUE_MIN, VALUE_MAX, value_t'(1)};
            for (k = 0; k < vals.size(); k++)
                send_word(vals[k], k == vals.size() - 1);
            wait_drained();
        end
    endtask

    // Sorted, reversed and all-equal sequences, back to back
    task automatic test_orderings();
        int k;
        begin
            max_gap = 0;
            send_sequence(5, FILL_RISING);
            send_sequence(5, FILL_FALLING);
            for (k = 0; k < 4; k++)
                send_word(value_t'(-7), k == 3);
            max_gap = 12;
            wait_drained();
        end
    endtask

    // Fill the store, drop the tail words (last among them), then a fresh sequence
    task automatic test_overflow();
        begin
            max_gap = 0;
            send_sequence(MAX_ITEMS + 2, FILL_NARROW);
            max_gap = 12;
            send_word(value_t'(5), 1'b1);
            wait_drained();
        end
    endtask

    // Mostly short sequences with mixed fills; bursts and idle phases alternate
    task automatic test_random_sequences();
        int    target;
        int    seq_idx;
        int    len;
        fill_t fill;
        begin
            target  = words_sent + RANDOM_WORDS;
            seq_idx = 0;
            while (words_sent < target)
            begin
                if (seq_idx % 16 == 0)
                begin
                    wait_drained();
                    max_gap = ($urandom_range(3, 0) == 0) ? 0 : 12;
                end
                if ($urandom_range(9, 0) == 0)
                    len = $urandom_range(64, 17);
                else
                    len = $urandom_range(16, 1);
                fill = fill_t'($urandom_range(3, 0));
                send_sequence(len, fill);
                seq_idx++;
            end
            wait_drained();
        end
    endtask

    // Compare each result word with the oldest owed one
    always @(posedge clk)
    begin : check_results
        icms_out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result count=%0d overflowed=%0b",
                                       result.inversion_count, result.overflowed));
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (result.inversion_count !== want.inversion_count)
                    note_failure($sformatf("inversion_count: expected %0d, got %0d",
                                           want.inversion_count, result.inversion_count));
                if (result.overflowed !== want.overflowed)
                    note_failure($sformatf("overflowed: expected %0b, got %0b",
                                           want.overflowed, result.overflowed));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        in_data       = '0;
        open_overflow = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_word();
        test_extreme_values();
        test_orderings();
        test_overflow();
        test_random_sequences();

        // Let any stray result show up before closing
        wait_drained();
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));

        $display("Sent %0d words in %0d sequences, %0d with dropped words.",
                 words_sent, sequences_closed, overflow_closes);
        $display("Checked %0d results, %0d failures.", results_checked, failures);
        if (failures == 0)
            $display("inversion_count_merge_sort_top regression: pass");
        else
            $display("inversion_count_merge_sort_top regression: fail");
        $finish;
    end

endmodule

### files.f
hdl/icms_pkg.sv
hdl/inversion_count_merge_sort_top.sv
hdl/icms_checker.sv
verif/tb_top.sv
